// ----- rtl/rcde_pkg.sv -----
// ----------------------------------------------------------------------------
// rcde_pkg
// Shared constants, codes and types of the raster canvas draw engine.
// ----------------------------------------------------------------------------
package rcde_pkg;

  localparam int MAX_WIDTH        = 320;
  localparam int MAX_HEIGHT       = 200;
  localparam int STACK_DEPTH      = 32000;
  localparam int MAX_BRUSH_RADIUS = 2;

  localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int PA_W      = $clog2(PIX_DEPTH);
  localparam int SA_W      = $clog2(STACK_DEPTH);
  // stack entries hold x in -1..MAX_WIDTH and y in -1..MAX_HEIGHT, signed
  localparam int SX_W      = $clog2(MAX_WIDTH + 1) + 1;
  localparam int SY_W      = $clog2(MAX_HEIGHT + 1) + 1;
  localparam int SE_W      = SX_W + SY_W;
  // working coordinates: 9-bit inputs plus brush reach, signed
  localparam int CW        = 11;
  localparam int EW        = CW + 2;

  typedef enum logic [2:0] {
    OP_READ  = 3'd0,
    OP_STAMP = 3'd1,
    OP_LINE  = 3'd2,
    OP_RECT  = 3'd3,
    OP_FILL  = 3'd4,
    OP_CLEAR = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_RADIUS = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_READ_WAIT,
    ST_STAMP_SETUP,
    ST_STAMP_RUN,
    ST_LINE_STEP,
    ST_RECT_PT,
    ST_RECT_ADV,
    ST_FILL_START,
    ST_FILL_START_CHK,
    ST_FILL_POP,
    ST_FILL_POP_WAIT,
    ST_FILL_CHK,
    ST_FILL_PIX_CHK,
    ST_FILL_PUSH,
    ST_CLEAR,
    ST_DONE
  } state_e;

endpackage

// ----- rtl/rcde_ram.sv -----
// ----------------------------------------------------------------------------
// rcde_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module rcde_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ----- rtl/raster_canvas_draw_engine_top.sv -----
// ----------------------------------------------------------------------------
// raster_canvas_draw_engine_top
// Drawing engine over an 8-bit-per-pixel canvas held in on-chip RAM.
// ----------------------------------------------------------------------------
// Use: one command request per s_axis transfer, one result per command on
// m_axis. cfg_ready_o is always high; the user must write config (width,
// height, brush radius) on the cfg channel only while the engine is idle;
// the engine does not enforce this. Work goes through the single pixel RAM
// port (one access per cycle). A read is one pixel read; other commands:
//   stamp  : (2r+1)^2 pixel writes (fewer when clipped)
//   line   : per Bresenham point one stamp
//   rect   : two stamps (opposite edges) per step along x, then along y
//   fill   : per painted pixel one pixel read, one write and four pushes
//   clear  : 64000 pixel writes, one per pixel
// A command is taken only when the engine is idle. The result sits in an
// output register; the next command may be taken while it waits. If a
// second result finishes before the first is taken, the engine holds in
// its final state until the receiver takes the first one.
// Reset empties the output register and restores 320 x 200, radius 0. The
// canvas is not cleared: issue a clear command before drawing.
// ----------------------------------------------------------------------------
module raster_canvas_draw_engine_top
  import rcde_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // opcode[2:0], x_start[11:3], y_start[19:12], x_end[28:20], y_end[36:29],
  // paint_color[44:37], zero pad
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // read_color[7:0], stack_full[8], zero pad
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  state_e state_q, state_d;

  logic [8:0] cfg_w_q;
  logic [7:0] cfg_h_q;
  logic [1:0] cfg_r_q;
  logic [8:0] eff_w;
  logic [7:0] eff_h;
  logic [1:0] eff_r;

  logic [2:0] op_q;
  logic [7:0] color_q;
  logic signed [CW-1:0] cur_x_q, cur_y_q, end_x_q, end_y_q;
  logic signed [CW-1:0] lx_q, hx_q, hy_q, px_q, py_q;
  logic signed [EW-1:0] dx_q, dy_q, err_q;
  logic                 neg_x_q, neg_y_q;
  logic signed [CW-1:0] rx0_q, rx1_q, ry0_q, ry1_q, ri_q;
  logic                 rsub_q, rvert_q;
  logic [7:0]           target_q;
  logic [SA_W-1:0]      top_q;
  logic [1:0]           push_q;
  logic [PA_W-1:0]      clr_q;
  logic [7:0]           res_rd_q;
  logic                 res_full_q;
  logic                 m_valid_q;
  logic [8:0]           m_data_q;

  logic signed [CW-1:0] w_s, h_s, r_s;
  logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y, lx_c, hx_c, ly_c, hy_c;
  logic                 stamp_empty, in_canvas, line_end, top_ok, out_free;
  logic signed [EW-1:0] e2;
  logic signed [CW-1:0] pix_x, pix_y;

  logic            pix_we;
  logic [PA_W-1:0] pix_addr;
  logic [7:0]      pix_wdata, pix_rdata;
  logic            stk_we;
  logic [SA_W-1:0] stk_addr;
  logic [SE_W-1:0] stk_wdata, stk_rdata;
  logic signed [SX_W-1:0] nb_x;
  logic signed [SY_W-1:0] nb_y;

  logic in_acc;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_data_q};
  assign out_free      = !m_valid_q || m_axis_tready;

  // effective configuration
  always_comb begin
    eff_w = cfg_w_q;
    if (cfg_w_q == 9'd0) eff_w = 9'd1;
    else if (32'(cfg_w_q) > MAX_WIDTH) eff_w = 9'(MAX_WIDTH);
    eff_h = cfg_h_q;
    if (cfg_h_q == 8'd0) eff_h = 8'd1;
    else if (32'(cfg_h_q) > MAX_HEIGHT) eff_h = 8'(MAX_HEIGHT);
    eff_r = cfg_r_q;
    if (32'(cfg_r_q) > MAX_BRUSH_RADIUS) eff_r = 2'(MAX_BRUSH_RADIUS);
  end

  assign w_s = signed'(CW'(eff_w));
  assign h_s = signed'(CW'(eff_h));
  assign r_s = signed'(CW'(eff_r));

  // brush clipping around the current point
  always_comb begin
    lo_x = cur_x_q - r_s;
    hi_x = cur_x_q + r_s;
    lo_y = cur_y_q - r_s;
    hi_y = cur_y_q + r_s;
    lx_c = (lo_x < 0) ? '0 : lo_x;
    ly_c = (lo_y < 0) ? '0 : lo_y;
    hx_c = (hi_x >= w_s) ? w_s - CW'(1) : hi_x;
    hy_c = (hi_y >= h_s) ? h_s - CW'(1) : hi_y;
    stamp_empty = (lx_c > hx_c) || (ly_c > hy_c);
  end

  assign in_canvas = (cur_x_q >= 0) && (cur_y_q >= 0) && (cur_x_q < w_s) && (cur_y_q < h_s);
  assign line_end  = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);
  assign e2        = err_q <<< 1;
  assign top_ok    = (32'(top_q) + 4) < STACK_DEPTH;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (s_axis_tdata[2:0])
            OP_READ:  state_d = ST_READ;
            OP_STAMP: state_d = ST_STAMP_SETUP;
            OP_LINE:  state_d = ST_STAMP_SETUP;
            OP_RECT:  state_d = ST_RECT_PT;
            OP_FILL:  state_d = ST_FILL_START;
            OP_CLEAR: state_d = ST_CLEAR;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_READ:        state_d = in_canvas ? ST_READ_WAIT : ST_DONE;
      ST_READ_WAIT:   state_d = ST_DONE;
      ST_STAMP_SETUP: begin
        if (!stamp_empty) state_d = ST_STAMP_RUN;
        else if (op_q == OP_LINE) state_d = ST_LINE_STEP;
        else if (op_q == OP_RECT) state_d = ST_RECT_ADV;
        else state_d = ST_DONE;
      end
      ST_STAMP_RUN: begin
        if (px_q == hx_q && py_q == hy_q) begin
          if (op_q == OP_LINE) state_d = ST_LINE_STEP;
          else if (op_q == OP_RECT) state_d = ST_RECT_ADV;
          else state_d = ST_DONE;
        end
      end
      ST_LINE_STEP:   state_d = line_end ? ST_DONE : ST_STAMP_SETUP;
      ST_RECT_PT:     state_d = ST_STAMP_SETUP;
      ST_RECT_ADV: begin
        if (rsub_q && rvert_q && ri_q == ry1_q) state_d = ST_DONE;
        else state_d = ST_RECT_PT;
      end
      ST_FILL_START:     state_d = in_canvas ? ST_FILL_START_CHK : ST_DONE;
      ST_FILL_START_CHK: state_d = (pix_rdata == color_q) ? ST_DONE : ST_FILL_POP;
      ST_FILL_POP:       state_d = (top_q == '0) ? ST_DONE : ST_FILL_POP_WAIT;
      ST_FILL_POP_WAIT:  state_d = ST_FILL_CHK;
      ST_FILL_CHK:       state_d = in_canvas ? ST_FILL_PIX_CHK : ST_FILL_POP;
      ST_FILL_PIX_CHK: begin
        if (pix_rdata == target_q && top_ok) state_d = ST_FILL_PUSH;
        else state_d = ST_FILL_POP;
      end
      ST_FILL_PUSH:   state_d = (push_q == 2'd3) ? ST_FILL_POP : ST_FILL_PUSH;
      ST_CLEAR:       state_d = (32'(clr_q) == PIX_DEPTH - 1) ? ST_DONE : ST_CLEAR;
      ST_DONE:        state_d = out_free ? ST_IDLE : ST_DONE;
      default:        state_d = ST_IDLE;
    endcase
  end

  // memory requests
  always_comb begin
    pix_we    = 1'b0;
    pix_x     = cur_x_q;
    pix_y     = cur_y_q;
    pix_wdata = color_q;
    stk_we    = 1'b0;
    stk_addr  = top_q - SA_W'(1);
    nb_x      = SX_W'(cur_x_q);
    nb_y      = SY_W'(cur_y_q);
    unique case (push_q)
      2'd0: nb_x = SX_W'(cur_x_q) + SX_W'(1);
      2'd1: nb_x = SX_W'(cur_x_q) - SX_W'(1);
      2'd2: nb_y = SY_W'(cur_y_q) + SY_W'(1);
      2'd3: nb_y = SY_W'(cur_y_q) - SY_W'(1);
      default: ;
    endcase
    stk_wdata = {nb_y, nb_x};
    unique case (state_q)
      ST_STAMP_RUN: begin
        pix_we = 1'b1;
        pix_x  = px_q;
        pix_y  = py_q;
      end
      ST_FILL_START_CHK: begin
        // seed entry is the start point itself
        stk_we    = (pix_rdata != color_q);
        stk_addr  = '0;
        stk_wdata = {SY_W'(cur_y_q), SX_W'(cur_x_q)};
      end
      ST_FILL_PIX_CHK: pix_we = (pix_rdata == target_q);
      ST_FILL_PUSH: begin
        stk_we   = 1'b1;
        stk_addr = top_q + SA_W'(push_q);
      end
      ST_CLEAR: pix_we = 1'b1;
      default: ;
    endcase
    if (state_q == ST_CLEAR) begin
      pix_addr = clr_q;
    end else begin
      pix_addr = PA_W'(pix_y[CW-2:0]) * PA_W'(MAX_WIDTH) + PA_W'(pix_x[CW-2:0]);
    end
  end

  rcde_ram #(.DEPTH(PIX_DEPTH), .WIDTH(8)) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .addr_i  (pix_addr),
    .wdata_i (pix_wdata),
    .rdata_o (pix_rdata)
  );

  rcde_ram #(.DEPTH(STACK_DEPTH), .WIDTH(SE_W)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .addr_i  (stk_addr),
    .wdata_i (stk_wdata),
    .rdata_o (stk_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      cfg_w_q   <= 9'(MAX_WIDTH);
      cfg_h_q   <= 8'(MAX_HEIGHT);
      cfg_r_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_WIDTH:  cfg_w_q <= cfg_data_i;
          CFG_HEIGHT: cfg_h_q <= cfg_data_i[7:0];
          CFG_RADIUS: cfg_r_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (state_q == ST_DONE && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        op_q       <= s_axis_tdata[2:0];
        cur_x_q    <= signed'(CW'(s_axis_tdata[11:3]));
        cur_y_q    <= signed'(CW'(s_axis_tdata[19:12]));
        end_x_q    <= signed'(CW'(s_axis_tdata[28:20]));
        end_y_q    <= signed'(CW'(s_axis_tdata[36:29]));
        color_q    <= s_axis_tdata[44:37];
        res_rd_q   <= '0;
        res_full_q <= 1'b0;
        clr_q      <= '0;
        top_q      <= '0;
        push_q     <= '0;
        rsub_q     <= 1'b0;
        rvert_q    <= 1'b0;
        neg_x_q    <= !(s_axis_tdata[11:3] < s_axis_tdata[28:20]);
        neg_y_q    <= !(s_axis_tdata[19:12] < s_axis_tdata[36:29]);
        dx_q <= (s_axis_tdata[28:20] > s_axis_tdata[11:3]) ?
                signed'(EW'(s_axis_tdata[28:20] - s_axis_tdata[11:3])) :
                signed'(EW'(s_axis_tdata[11:3] - s_axis_tdata[28:20]));
        dy_q <= (s_axis_tdata[36:29] > s_axis_tdata[19:12]) ?
                signed'(EW'(s_axis_tdata[36:29] - s_axis_tdata[19:12])) :
                signed'(EW'(s_axis_tdata[19:12] - s_axis_tdata[36:29]));
        err_q <= ((s_axis_tdata[28:20] > s_axis_tdata[11:3]) ?
                  signed'(EW'(s_axis_tdata[28:20] - s_axis_tdata[11:3])) :
                  signed'(EW'(s_axis_tdata[11:3] - s_axis_tdata[28:20])))
               - ((s_axis_tdata[36:29] > s_axis_tdata[19:12]) ?
                  signed'(EW'(s_axis_tdata[36:29] - s_axis_tdata[19:12])) :
                  signed'(EW'(s_axis_tdata[19:12] - s_axis_tdata[36:29])));
        if (s_axis_tdata[11:3] > s_axis_tdata[28:20]) begin
          rx0_q <= signed'(CW'(s_axis_tdata[28:20]));
          rx1_q <= signed'(CW'(s_axis_tdata[11:3]));
          ri_q  <= signed'(CW'(s_axis_tdata[28:20]));
        end else begin
          rx0_q <= signed'(CW'(s_axis_tdata[11:3]));
          rx1_q <= signed'(CW'(s_axis_tdata[28:20]));
          ri_q  <= signed'(CW'(s_axis_tdata[11:3]));
        end
        if (s_axis_tdata[19:12] > s_axis_tdata[36:29]) begin
          ry0_q <= signed'(CW'(s_axis_tdata[36:29]));
          ry1_q <= signed'(CW'(s_axis_tdata[19:12]));
        end else begin
          ry0_q <= signed'(CW'(s_axis_tdata[19:12]));
          ry1_q <= signed'(CW'(s_axis_tdata[36:29]));
        end
      end
      ST_READ_WAIT: res_rd_q <= pix_rdata;
      ST_STAMP_SETUP: begin
        lx_q <= lx_c;
        hx_q <= hx_c;
        hy_q <= hy_c;
        px_q <= lx_c;
        py_q <= ly_c;
      end
      ST_STAMP_RUN: begin
        if (px_q == hx_q) begin
          px_q <= lx_q;
          py_q <= py_q + CW'(1);
        end else begin
          px_q <= px_q + CW'(1);
        end
      end
      ST_LINE_STEP: begin
        // both tests use the error term from before this step
        err_q <= err_q - ((e2 > -dy_q) ? dy_q : '0) + ((e2 < dx_q) ? dx_q : '0);
        if (e2 > -dy_q) cur_x_q <= neg_x_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
        if (e2 < dx_q)  cur_y_q <= neg_y_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
      end
      ST_RECT_PT: begin
        if (!rvert_q) begin
          cur_x_q <= ri_q;
          cur_y_q <= rsub_q ? ry1_q : ry0_q;
        end else begin
          cur_x_q <= rsub_q ? rx1_q : rx0_q;
          cur_y_q <= ri_q;
        end
      end
      ST_RECT_ADV: begin
        rsub_q <= !rsub_q;
        if (rsub_q) begin
          if (!rvert_q && ri_q == rx1_q) begin
            rvert_q <= 1'b1;
            ri_q    <= ry0_q;
          end else begin
            ri_q <= ri_q + CW'(1);
          end
        end
      end
      ST_FILL_START_CHK: begin
        target_q <= pix_rdata;
        top_q    <= SA_W'(1);
      end
      ST_FILL_POP: top_q <= top_q - SA_W'(1);
      ST_FILL_POP_WAIT: begin
        cur_x_q <= CW'(signed'(stk_rdata[SX_W-1:0]));
        cur_y_q <= CW'(signed'(stk_rdata[SE_W-1:SX_W]));
      end
      ST_FILL_PIX_CHK: begin
        push_q <= '0;
        if (pix_rdata == target_q && !top_ok) res_full_q <= 1'b1;
      end
      ST_FILL_PUSH: begin
        push_q <= push_q + 2'd1;
        if (push_q == 2'd3) top_q <= top_q + SA_W'(4);
      end
      ST_CLEAR: clr_q <= clr_q + PA_W'(1);
      ST_DONE: if (out_free) m_data_q <= {res_full_q, res_rd_q};
      default: ;
    endcase
  end

endmodule

// ----- rtl/rcde_checker.sv -----
// ----------------------------------------------------------------------------
// rcde_checker
// Port-level checks on the draw engine, bound to the top level.
// ----------------------------------------------------------------------------
module rcde_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  // result held while the receiver stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed under stall");

  // engine is busy in the cycle after taking a command
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken back to back");

  // pad bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)
    else $error("result pad bits set");

  // a new result only comes out of a busy engine
  a_result_needs_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result with no command");

endmodule

bind raster_canvas_draw_engine_top rcde_checker u_rcde_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the raster canvas draw engine: a clocked driver
// feeds command requests from a queue, a canvas predictor computes each
// result, a clocked monitor compares results in order. Random idling,
// a long receiver hold-off and several canvas/brush settings are covered.
// ----------------------------------------------------------------------------
module tb_top;
  import rcde_pkg::*;

  localparam logic [2:0] OP_RSVD_A = 3'd6;
  localparam logic [2:0] OP_RSVD_B = 3'd7;
  localparam int         IDLE_LIMIT = 2000000;

  typedef struct packed {
    logic [2:0] op;
    logic [8:0] xs;
    logic [7:0] ys;
    logic [8:0] xe;
    logic [7:0] ye;
    logic [7:0] col;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_color;
    logic       stack_full;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [8:0]  cfg_data_i = '0;

  raster_canvas_draw_engine_top dut (
    .clk_i, .rst_ni, .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // ---------------- canvas predictor ----------------
  logic [7:0] canvas [PIX_DEPTH];
  int         stk_x [STACK_DEPTH];
  int         stk_y [STACK_DEPTH];
  int         reg_w = 320, reg_h = 200, reg_r = 0;

  function automatic int act_w();
    return (reg_w < 1) ? 1 : (reg_w > MAX_WIDTH) ? MAX_WIDTH : reg_w;
  endfunction
  function automatic int act_h();
    return (reg_h < 1) ? 1 : (reg_h > MAX_HEIGHT) ? MAX_HEIGHT : reg_h;
  endfunction
  function automatic int act_r();
    return (reg_r > MAX_BRUSH_RADIUS) ? MAX_BRUSH_RADIUS : reg_r;
  endfunction

  function automatic void brush_at(int cx, int cy, logic [7:0] c);
    int r, lx, hx, ly, hy;
    r = act_r();
    lx = cx - r; hx = cx + r; ly = cy - r; hy = cy + r;
    if (lx < 0) lx = 0;
    if (ly < 0) ly = 0;
    if (hx >= act_w()) hx = act_w() - 1;
    if (hy >= act_h()) hy = act_h() - 1;
    for (int y = ly; y <= hy; y++)
      for (int x = lx; x <= hx; x++) canvas[y * MAX_WIDTH + x] = c;
  endfunction

  function automatic void trace_line(int x0, int y0, int x1, int y1, logic [7:0] c);
    int dx, dy, sx, sy, err, e2;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    forever begin
      brush_at(x0, y0, c);
      if (x0 == x1 && y0 == y1) break;
      e2 = 2 * err;
      if (e2 > -dy) begin err -= dy; x0 += sx; end
      if (e2 < dx) begin err += dx; y0 += sy; end
    end
  endfunction

  function automatic void trace_rect(int x0, int y0, int x1, int y1, logic [7:0] c);
    int t;
    if (x0 > x1) begin t = x0; x0 = x1; x1 = t; end
    if (y0 > y1) begin t = y0; y0 = y1; y1 = t; end
    for (int i = x0; i <= x1; i++) begin brush_at(i, y0, c); brush_at(i, y1, c); end
    for (int i = y0; i <= y1; i++) begin brush_at(x0, i, c); brush_at(x1, i, c); end
  endfunction

  function automatic logic flood_region(int cx, int cy, logic [7:0] c);
    int w, h, top, x, y;
    logic [7:0] tgt;
    logic dropped;
    w = act_w(); h = act_h(); dropped = 1'b0;
    if (cx >= w || cy >= h) return 1'b0;
    tgt = canvas[cy * MAX_WIDTH + cx];
    if (tgt == c) return 1'b0;
    stk_x[0] = cx; stk_y[0] = cy; top = 1;
    while (top > 0) begin
      top--;
      x = stk_x[top]; y = stk_y[top];
      if (x < 0 || y < 0 || x >= w || y >= h) continue;
      if (canvas[y * MAX_WIDTH + x] != tgt) continue;
      canvas[y * MAX_WIDTH + x] = c;
      if (top + 4 < STACK_DEPTH) begin
        stk_x[top]     = x + 1; stk_y[top]     = y;
        stk_x[top + 1] = x - 1; stk_y[top + 1] = y;
        stk_x[top + 2] = x;     stk_y[top + 2] = y + 1;
        stk_x[top + 3] = x;     stk_y[top + 3] = y - 1;
        top += 4;
      end else dropped = 1'b1;
    end
    return dropped;
  endfunction

  function automatic res_t canvas_apply(cmd_t c);
    res_t r;
    r = '0;
    case (c.op)
      OP_READ:  if (c.xs < act_w() && c.ys < act_h()) r.read_color = canvas[c.ys * MAX_WIDTH + c.xs];
      OP_STAMP: brush_at(c.xs, c.ys, c.col);
      OP_LINE:  trace_line(c.xs, c.ys, c.xe, c.ye, c.col);
      OP_RECT:  trace_rect(c.xs, c.ys, c.xe, c.ye, c.col);
      OP_FILL:  r.stack_full = flood_region(c.xs, c.ys, c.col);
      OP_CLEAR: for (int i = 0; i < PIX_DEPTH; i++) canvas[i] = c.col;
      default: ;
    endcase
    return r;
  endfunction

  // ---------------- bookkeeping ----------------
  cmd_t cmd_q [$];
  res_t result_q [$];
  cmd_t cur_cmd;
  int   errors = 0;
  int   src_gap = 0, sink_gap = 0, hold_cnt = 0;
  int   hold_tok = 0, hold_seen = 0;
  bit   quiet = 1'b0;
  int   idle_cycles = 0;

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    logic busy;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.push_back(canvas_apply(cur_cmd));
        busy = 1'b0;
      end
      if (!busy) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd <= cmd_q[0];
          s_axis_tdata <= {3'b0, cmd_q[0].col, cmd_q[0].ye, cmd_q[0].xe,
                           cmd_q[0].ys, cmd_q[0].xs, cmd_q[0].op};
          s_axis_tvalid <= 1'b1;
          void'(cmd_q.pop_front());
          if (!quiet && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 3);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          flag_mismatch("unexpected result", m_axis_tdata[7:0], 0);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata[7:0] !== want.read_color)
            flag_mismatch("read_color", m_axis_tdata[7:0], want.read_color);
          if (m_axis_tdata[8] !== want.stack_full)
            flag_mismatch("stack_full", m_axis_tdata[8], want.stack_full);
        end
      end
      if (hold_seen != hold_tok) begin
        hold_seen <= hold_tok;
        hold_cnt <= 400;          // long hold-off so the engine backs up
        m_axis_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) sink_gap <= $urandom_range(1, 3);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[raster_canvas_draw_engine_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- stimulus ----------------
  task automatic cfg_write(cfg_idx_e idx, int val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[8:0];
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    case (idx)
      CFG_WIDTH:  reg_w = val & 9'h1FF;
      CFG_HEIGHT: reg_h = val & 8'hFF;
      default:    reg_r = val & 2'h3;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // look after the edge's updates have settled so a request just taken
  // from the queue is not missed
  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (cmd_q.size() > 0 || s_axis_tvalid || result_q.size() > 0);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic cmd_t mk(logic [2:0] op, int xs, int ys, int xe, int ye, int col);
    cmd_t c;
    c.op = op; c.xs = 9'(xs); c.ys = 8'(ys); c.xe = 9'(xe); c.ye = 8'(ye);
    c.col = 8'(col);
    return c;
  endfunction

  function automatic cmd_t rand_cmd(bit fills_ok);
    cmd_t c;
    int   pick, xl, yl, xs, ys, xe, ye;
    xl = (act_w() + 3 > 60) ? 60 : act_w() + 3;
    yl = (act_h() + 3 > 40) ? 40 : act_h() + 3;
    pick = $urandom_range(0, 99);
    if (pick < 30)      c.op = OP_READ;
    else if (pick < 50) c.op = OP_STAMP;
    else if (pick < 67) c.op = OP_LINE;
    else if (pick < 82) c.op = OP_RECT;
    else if (pick < 94) c.op = fills_ok ? OP_FILL : OP_READ;
    else if (pick < 97) c.op = OP_RSVD_A;
    else                c.op = OP_RSVD_B;
    if ($urandom_range(0, 9) == 0) begin
      xs = $urandom_range(0, 319); ys = $urandom_range(0, 199);
    end else begin
      xs = $urandom_range(0, xl); ys = $urandom_range(0, yl);
    end
    // keep line and rect spans short so the engine stays fast
    xe = xs + $urandom_range(0, 24) - 12;
    ye = ys + $urandom_range(0, 16) - 8;
    if (xe < 0) xe = 0;
    if (xe > 319) xe = 319;
    if (ye < 0) ye = 0;
    if (ye > 199) ye = 199;
    if (c.op == OP_FILL && $urandom_range(0, 1) == 0) begin
      xs = $urandom_range(0, xl); ys = $urandom_range(0, yl);
    end
    c.xs = 9'(xs); c.ys = 8'(ys); c.xe = 9'(xe); c.ye = 8'(ye);
    c.col = 8'($urandom_range(0, 255));
    if (c.op == OP_FILL) c.col = 8'($urandom_range(0, 3));
    return c;
  endfunction

  initial begin
    int phase_w [6] = '{24, 1, 0, 511, 17, 320};
    int phase_h [6] = '{16, 1, 0, 255, 9, 30};
    int phase_r [6] = '{0, 1, 3, 0, 2, 1};
    bit phase_f [6] = '{1, 1, 1, 0, 1, 0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: clear, then a tall-stack fill on a wide band
    cmd_q.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 8'h11));
    drain();
    cfg_write(CFG_HEIGHT, 60);
    cmd_q.push_back(mk(OP_FILL, 5, 5, 0, 0, 8'h07));
    cmd_q.push_back(mk(OP_READ, 5, 5, 0, 0, 0));
    cmd_q.push_back(mk(OP_READ, 319, 59, 0, 0, 0));
    cmd_q.push_back(mk(OP_READ, 0, 100, 0, 0, 0));        // below active canvas
    cmd_q.push_back(mk(OP_STAMP, 0, 0, 0, 0, 8'hFF));
    cmd_q.push_back(mk(OP_READ, 0, 0, 0, 0, 0));
    drain();
    cfg_write(CFG_RADIUS, 3);
    cmd_q.push_back(mk(OP_STAMP, 319, 59, 0, 0, 8'hA5));  // corner clip
    cmd_q.push_back(mk(OP_STAMP, 319, 199, 0, 0, 8'h5A)); // wholly off canvas
    cmd_q.push_back(mk(OP_READ, 318, 58, 0, 0, 0));
    cmd_q.push_back(mk(OP_LINE, 0, 0, 30, 10, 8'h80));
    cmd_q.push_back(mk(OP_LINE, 40, 20, 30, 50, 8'h01));
    cmd_q.push_back(mk(OP_RECT, 50, 40, 10, 5, 8'h3C));   // reversed corners
    cmd_q.push_back(mk(OP_READ, 10, 5, 0, 0, 0));
    cmd_q.push_back(mk(OP_FILL, 10, 5, 0, 0, 8'h3C));     // same colour
    cmd_q.push_back(mk(OP_FILL, 2, 150, 0, 0, 8'h02));    // off canvas
    cmd_q.push_back(mk(OP_RSVD_A, 511, 255, 511, 255, 8'hFF));
    cmd_q.push_back(mk(OP_RSVD_B, 0, 0, 0, 0, 0));
    cmd_q.push_back(mk(OP_READ, 20, 20, 0, 0, 0));
    drain();

    for (int p = 0; p < 6; p++) begin
      cfg_write(CFG_WIDTH, phase_w[p]);
      cfg_write(CFG_HEIGHT, phase_h[p]);
      cfg_write(CFG_RADIUS, phase_r[p]);
      if (p == 5) quiet = 1'b1;
      if (p == 2) cmd_q.push_back(mk(OP_CLEAR, 0, 0, 0, 0, $urandom_range(0, 255)));
      for (int i = 0; i < 240; i++) cmd_q.push_back(rand_cmd(phase_f[p]));
      if (p == 1) begin
        repeat (50) @(posedge clk_i);
        hold_tok++;
      end
      drain();
    end

    if (errors == 0 && result_q.size() == 0) $display("[raster_canvas_draw_engine_top] OK");
    else $display("[raster_canvas_draw_engine_top] ERROR");
    $finish;
  end

endmodule
